[hw/rtl/sfa_pkg.sv]
// Shared types and constants of the sprite frame animator.
package sfa_pkg;

	localparam int FRAME_W    = 16;
	localparam int TIME_W     = 32;
	localparam int COLS_W     = 8;
	localparam int CELL_W     = 12;
	localparam int RECT_W     = 28;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLUMNS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd6;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SET  = 1'b1;

	typedef struct packed {
		logic [FRAME_W-1:0] first_frame;
		logic [FRAME_W-1:0] last_frame;
		logic               loop_enable;
		logic [TIME_W-1:0]  frame_period;
		logic [COLS_W-1:0]  sheet_columns;
		logic [CELL_W-1:0]  cell_width;
		logic [CELL_W-1:0]  cell_height;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_ADD,
		ST_TICK_STEP,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic acc_add;
		logic frame_step;
		logic div_init;
		logic div_step;
		logic mul;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

[hw/rtl/sfa_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface sfa_in_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic [sfa_pkg::TIME_W-1:0]         elapsed_time;
	logic signed [sfa_pkg::FRAME_W-1:0] frame_value;

	modport source (output valid, func, elapsed_time, frame_value, input ready);
	modport sink (input valid, func, elapsed_time, frame_value, output ready);
endinterface

interface sfa_out_if;
	logic                        valid;
	logic                        ready;
	logic [sfa_pkg::FRAME_W-1:0] frame_now;
	logic [sfa_pkg::RECT_W-1:0]  rect_left;
	logic [sfa_pkg::RECT_W-1:0]  rect_top;
	logic [sfa_pkg::RECT_W-1:0]  rect_right;
	logic [sfa_pkg::RECT_W-1:0]  rect_bottom;
	logic                        done_flag;

	modport source (output valid, frame_now, rect_left, rect_top, rect_right, rect_bottom,
		done_flag, input ready);
	modport sink (input valid, frame_now, rect_left, rect_top, rect_right, rect_bottom,
		done_flag, output ready);
endinterface

[hw/rtl/sfa_ctrl.sv]
// Controller state machine: sequences tick update, divide, multiply and result load.
module sfa_ctrl #(
	parameter int IW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_func,
	input  sfa_pkg::sts_t       sts,
	output sfa_pkg::cmd_t       cmd
);

	localparam int CNTW = $clog2(IW);

	sfa_pkg::state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfa_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		case (state_q)
			sfa_pkg::ST_IDLE: begin
				// the input beat is taken here; ready follows the take command
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = (in_func == sfa_pkg::FUNC_TICK) ? sfa_pkg::ST_TICK_ADD
						: sfa_pkg::ST_DIV_INIT;
				end
			end
			sfa_pkg::ST_TICK_ADD: begin
				cmd.acc_add = 1'b1;
				state_d     = sfa_pkg::ST_TICK_STEP;
			end
			sfa_pkg::ST_TICK_STEP: begin
				cmd.frame_step = 1'b1;
				state_d        = sfa_pkg::ST_DIV_INIT;
			end
			sfa_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = sfa_pkg::ST_DIV_RUN;
			end
			sfa_pkg::ST_DIV_RUN: begin
				// one quotient bit per cycle, index bits from the top down
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNTW'(IW - 1)) begin
					state_d = sfa_pkg::ST_MUL;
				end
			end
			sfa_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = sfa_pkg::ST_OUT;
			end
			sfa_pkg::ST_OUT: begin
				// hold until the result register is free
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/sfa_dp.sv]
// Datapath: animation state, column/row divider, rectangle multipliers, result register.
module sfa_dp #(
	parameter int IW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfa_pkg::cfg_t     cfg,
	input  sfa_pkg::cmd_t     cmd,
	output sfa_pkg::sts_t     sts,
	sfa_in_if.sink            in_ch,
	sfa_out_if.source         out_ch
);

	localparam int TW = sfa_pkg::TIME_W;
	localparam int RW = sfa_pkg::RECT_W;
	localparam int CW = (IW + 1 > sfa_pkg::FRAME_W) ? IW + 1 : sfa_pkg::FRAME_W;
	localparam int DW = sfa_pkg::COLS_W;

	logic [TW-1:0] acc_q;
	logic [IW-1:0] index_q;
	logic          finished_q;
	logic          out_valid_q;

	logic [TW-1:0] elapsed_q;
	logic [IW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [RW-1:0] left_q;
	logic [RW-1:0] top_q;

	logic [sfa_pkg::FRAME_W-1:0] frame_now_q;
	logic [RW-1:0]               rect_left_q, rect_top_q, rect_right_q, rect_bottom_q;
	logic                        done_flag_q;

	logic          animated;
	logic [TW:0]   sum_w;
	logic [TW-1:0] sum_sat;
	logic [IW:0]   next_w;
	logic          out_of_range;
	logic [DW-1:0] cols;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW-1:0] rem_n;

	assign animated = cfg.last_frame > cfg.first_frame;
	assign sum_w    = {1'b0, acc_q} + {1'b0, elapsed_q};
	assign sum_sat  = sum_w[TW] ? '1 : sum_w[TW-1:0];

	assign next_w       = {1'b0, index_q} + (IW+1)'(1);
	assign out_of_range = (CW'(next_w) < CW'(cfg.first_frame))
		|| (CW'(next_w) > CW'(cfg.last_frame));

	assign cols  = (cfg.sheet_columns == '0) ? DW'(1) : cfg.sheet_columns;
	assign trial = {rem_q, quo_q[IW-1]};
	assign ge    = trial >= {1'b0, cols};
	assign rem_n = ge ? DW'(trial - {1'b0, cols}) : trial[DW-1:0];

	assign sts.out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = cmd.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			index_q     <= '0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take && in_ch.func == sfa_pkg::FUNC_SET && !in_ch.frame_value[15]) begin
				index_q    <= IW'(unsigned'(in_ch.frame_value));
				finished_q <= 1'b0;
			end
			if (cmd.acc_add && animated) begin
				acc_q <= sum_sat;
			end
			if (cmd.frame_step && animated && acc_q > cfg.frame_period) begin
				acc_q <= acc_q - cfg.frame_period;
				if (!out_of_range) begin
					index_q <= next_w[IW-1:0];
				end else if (cfg.loop_enable) begin
					index_q <= IW'(cfg.first_frame);
				end else begin
					index_q    <= IW'(cfg.last_frame);
					finished_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			elapsed_q <= in_ch.elapsed_time;
		end
		if (cmd.div_init) begin
			quo_q <= index_q;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[IW-2:0], ge};
			rem_q <= rem_n;
		end
		if (cmd.mul) begin
			left_q <= RW'(rem_q) * RW'(cfg.cell_width);
			top_q  <= RW'(quo_q) * RW'(cfg.cell_height);
		end
		if (cmd.load_out) begin
			frame_now_q   <= sfa_pkg::FRAME_W'(index_q);
			rect_left_q   <= left_q;
			rect_top_q    <= top_q;
			rect_right_q  <= left_q + RW'(cfg.cell_width);
			rect_bottom_q <= top_q + RW'(cfg.cell_height);
			done_flag_q   <= finished_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.frame_now   = frame_now_q;
	assign out_ch.rect_left   = rect_left_q;
	assign out_ch.rect_top    = rect_top_q;
	assign out_ch.rect_right  = rect_right_q;
	assign out_ch.rect_bottom = rect_bottom_q;
	assign out_ch.done_flag   = done_flag_q;

endmodule

[hw/rtl/sprite_frame_animator.sv]
// Sprite-sheet animation sequencer: one result beat per input beat.
// Tick items pass through accumulate and frame step, then every item through divider init,
// the restoring divider for column and row, the multiply and the result load.
// Flow: one item at a time; the next accept comes at the earliest in the cycle after
// the result is loaded, and the result load waits while the result register is held.
// Reset: accumulator, frame index and done flag clear; registers take their defaults.
module sprite_frame_animator #(
	parameter int FRAME_INDEX_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [sfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfa_pkg::CFG_DATA_W-1:0]    cfg_data,
	sfa_in_if.sink                            in_ch,
	sfa_out_if.source                         out_ch
);

	sfa_pkg::cfg_t cfg_q;
	sfa_pkg::cmd_t cmd;
	sfa_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_frame   <= '0;
			cfg_q.last_frame    <= '0;
			cfg_q.loop_enable   <= 1'b0;
			cfg_q.frame_period  <= 32'h0001_0000;
			cfg_q.sheet_columns <= 8'd1;
			cfg_q.cell_width    <= 12'd2;
			cfg_q.cell_height   <= 12'd2;
		end else if (cfg_wen) begin
			case (cfg_index)
				sfa_pkg::REG_FIRST_FRAME:   cfg_q.first_frame   <= cfg_data[15:0];
				sfa_pkg::REG_LAST_FRAME:    cfg_q.last_frame    <= cfg_data[15:0];
				sfa_pkg::REG_LOOP_ENABLE:   cfg_q.loop_enable   <= cfg_data[0];
				sfa_pkg::REG_FRAME_PERIOD:  cfg_q.frame_period  <= cfg_data;
				sfa_pkg::REG_SHEET_COLUMNS: cfg_q.sheet_columns <= cfg_data[7:0];
				sfa_pkg::REG_CELL_WIDTH:    cfg_q.cell_width    <= cfg_data[11:0];
				sfa_pkg::REG_CELL_HEIGHT:   cfg_q.cell_height   <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	sfa_ctrl #(
		.IW(FRAME_INDEX_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_func  (in_ch.func),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfa_dp #(
		.IW(FRAME_INDEX_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.sts    (sts),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

[sim/tb_sprite_frame_animator.sv]
// Testbench for the sprite frame animator: predicts every result beat and checks it field by field.
`timescale 1ns / 100ps

module tb_sprite_frame_animator;

	typedef struct {
		logic [sfa_pkg::FRAME_W-1:0] frame_now;
		logic [sfa_pkg::RECT_W-1:0]  rect_left;
		logic [sfa_pkg::RECT_W-1:0]  rect_top;
		logic [sfa_pkg::RECT_W-1:0]  rect_right;
		logic [sfa_pkg::RECT_W-1:0]  rect_bottom;
		logic                        done_flag;
	} frame_result_t;

	// Tracks accumulator, frame index and done flag; holds the frames still due.
	class frame_tracker;
		sfa_pkg::cfg_t               regs;
		logic [sfa_pkg::TIME_W-1:0]  acc_time;
		logic [sfa_pkg::FRAME_W-1:0] cur_index;
		logic                        finished;
		frame_result_t               frames_due[$];
		int                          mismatches;

		function new();
			regs.first_frame   = '0;
			regs.last_frame    = '0;
			regs.loop_enable   = 1'b0;
			regs.frame_period  = 32'h0001_0000;
			regs.sheet_columns = 8'd1;
			regs.cell_width    = 12'd2;
			regs.cell_height   = 12'd2;
			acc_time   = '0;
			cur_index  = '0;
			finished   = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [sfa_pkg::CFG_IDX_W-1:0] index,
			logic [sfa_pkg::CFG_DATA_W-1:0] data);
			case (index)
				sfa_pkg::REG_FIRST_FRAME:   regs.first_frame   = data[sfa_pkg::FRAME_W-1:0];
				sfa_pkg::REG_LAST_FRAME:    regs.last_frame    = data[sfa_pkg::FRAME_W-1:0];
				sfa_pkg::REG_LOOP_ENABLE:   regs.loop_enable   = data[0];
				sfa_pkg::REG_FRAME_PERIOD:  regs.frame_period  = data[sfa_pkg::TIME_W-1:0];
				sfa_pkg::REG_SHEET_COLUMNS: regs.sheet_columns = data[sfa_pkg::COLS_W-1:0];
				sfa_pkg::REG_CELL_WIDTH:    regs.cell_width    = data[sfa_pkg::CELL_W-1:0];
				sfa_pkg::REG_CELL_HEIGHT:   regs.cell_height   = data[sfa_pkg::CELL_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_item(logic func, logic [sfa_pkg::TIME_W-1:0] elapsed,
			logic [sfa_pkg::FRAME_W-1:0] fval);
			logic [sfa_pkg::TIME_W:0]    sum;
			logic [sfa_pkg::FRAME_W:0]   nxt;
			longint unsigned             cols;
			longint unsigned             lft;
			longint unsigned             tp;
			frame_result_t               r;
			if (func == sfa_pkg::FUNC_TICK) begin
				if (regs.last_frame > regs.first_frame) begin
					sum = {1'b0, acc_time} + elapsed;
					acc_time = sum[sfa_pkg::TIME_W] ? '1 : sum[sfa_pkg::TIME_W-1:0];
					if (acc_time > regs.frame_period) begin
						acc_time = acc_time - regs.frame_period;
						nxt = {1'b0, cur_index} + 1'b1;
						// leave the range: wrap when looping, else hold at the end
						if (nxt < regs.first_frame || nxt > regs.last_frame) begin
							if (regs.loop_enable) begin
								nxt = {1'b0, regs.first_frame};
							end else begin
								nxt = {1'b0, regs.last_frame};
								finished = 1'b1;
							end
						end
						cur_index = nxt[sfa_pkg::FRAME_W-1:0];
					end
				end
			end else if (!fval[sfa_pkg::FRAME_W-1]) begin
				cur_index = fval;
				finished  = 1'b0;
			end
			cols = (regs.sheet_columns == 0) ? 64'd1 : 64'(regs.sheet_columns);
			lft  = (64'(cur_index) % cols) * 64'(regs.cell_width);
			tp   = (64'(cur_index) / cols) * 64'(regs.cell_height);
			r.frame_now   = cur_index;
			r.rect_left   = lft[sfa_pkg::RECT_W-1:0];
			r.rect_top    = tp[sfa_pkg::RECT_W-1:0];
			r.rect_right  = sfa_pkg::RECT_W'(lft + 64'(regs.cell_width));
			r.rect_bottom = sfa_pkg::RECT_W'(tp + 64'(regs.cell_height));
			r.done_flag   = finished;
			frames_due.push_back(r);
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_frame(frame_result_t got);
			frame_result_t want;
			if (frames_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with none expected, expected none actual frame %0h",
					$time, got.frame_now);
				return;
			end
			want = frames_due.pop_front();
			compare("frame_now", want.frame_now, got.frame_now);
			compare("rect_left", want.rect_left, got.rect_left);
			compare("rect_top", want.rect_top, got.rect_top);
			compare("rect_right", want.rect_right, got.rect_right);
			compare("rect_bottom", want.rect_bottom, got.rect_bottom);
			compare("done_flag", want.done_flag, got.done_flag);
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wen;
	logic [sfa_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sfa_pkg::CFG_DATA_W-1:0] cfg_data;

	sfa_in_if  in_bus();
	sfa_out_if out_bus();

	sprite_frame_animator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_bus),
		.out_ch    (out_bus)
	);

	frame_tracker tracker;
	logic         calm;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int pause_len();
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return int'($urandom_range(0, 18));
	endfunction

	task automatic send_beat(input logic func, input logic [sfa_pkg::TIME_W-1:0] elapsed,
		input logic [sfa_pkg::FRAME_W-1:0] fval);
		int gap;
		gap = pause_len();
		@(negedge clk);
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_bus.valid        <= 1'b1;
		in_bus.func         <= func;
		in_bus.elapsed_time <= elapsed;
		in_bus.frame_value  <= fval;
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
		tracker.take_item(func, elapsed, fval);
	endtask

	task automatic cfg_write(input logic [sfa_pkg::CFG_IDX_W-1:0] index,
		input logic [sfa_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		tracker.write_reg(index, data);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Hold the sender until every frame is back, then reprogram all registers.
	task automatic load_setup(input logic [15:0] f, input logic [15:0] l, input logic lp,
		input logic [31:0] p, input logic [7:0] c, input logic [11:0] w, input logic [11:0] h);
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (tracker.frames_due.size() > 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_write(sfa_pkg::REG_FIRST_FRAME, 32'(f));
		cfg_write(sfa_pkg::REG_LAST_FRAME, 32'(l));
		cfg_write(sfa_pkg::REG_LOOP_ENABLE, 32'(lp));
		cfg_write(sfa_pkg::REG_FRAME_PERIOD, p);
		cfg_write(sfa_pkg::REG_SHEET_COLUMNS, 32'(c));
		cfg_write(sfa_pkg::REG_CELL_WIDTH, 32'(w));
		cfg_write(sfa_pkg::REG_CELL_HEIGHT, 32'(h));
	endtask

	task automatic random_phase(input int n_items);
		logic [15:0] f;
		logic [15:0] l;
		logic [31:0] p;
		logic [7:0]  c;
		logic [11:0] w;
		logic [11:0] h;
		logic [31:0] span;
		logic [31:0] e;
		logic [15:0] v;
		int          lo;
		int          vi;
		case ($urandom_range(0, 5))
			0: begin
				f = 16'($urandom);
				l = 16'($urandom);
			end
			1: begin
				f = 16'hFFFF - 16'($urandom_range(0, 6));
				l = 16'hFFFF;
			end
			default: begin
				f = 16'($urandom_range(0, 60));
				l = f + 16'($urandom_range(1, 12));
			end
		endcase
		if ($urandom_range(0, 9) == 0)
			l = f;
		case ($urandom_range(0, 5))
			0: p = $urandom_range(0, 3);
			1: p = $urandom;
			2: p = '1;
			default: p = $urandom_range(1, 1 << 18);
		endcase
		case ($urandom_range(0, 3))
			0: c = 8'd0;
			1: c = 8'd255;
			default: c = 8'($urandom_range(1, 16));
		endcase
		case ($urandom_range(0, 3))
			0: w = 12'd0;
			1: w = 12'hFFF;
			default: w = 12'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: h = 12'd0;
			1: h = 12'hFFF;
			default: h = 12'($urandom);
		endcase
		load_setup(f, l, 1'($urandom_range(0, 1)), p, c, w, h);
		span = (p >= 32'h8000_0000) ? '1 : {p[30:0], 1'b1};
		repeat (n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 9))
					0: e = $urandom;
					1: e = '1;
					2: e = '0;
					default: e = $urandom_range(0, span);
				endcase
				send_beat(sfa_pkg::FUNC_TICK, e, 16'($urandom));
			end else begin
				case ($urandom_range(0, 7))
					0: v = 16'($urandom);
					1: v = 16'h8000 | 16'($urandom);
					default: begin
						lo = int'(f) - 2;
						vi = lo + int'($urandom_range(0, (l > f ? 32'(l - f) : 32'd0) + 4));
						if (vi < 0)
							vi = 0;
						v = 16'(vi) & 16'h7FFF;
					end
				endcase
				send_beat(sfa_pkg::FUNC_SET, $urandom, v);
			end
		end
	endtask

	// Result side: stall a random while before each beat, then check it.
	initial begin
		frame_result_t got;
		out_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = pause_len();
			@(negedge clk);
			if (stall > 0) begin
				out_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_bus.ready <= 1'b1;
			@(posedge clk);
			while (!out_bus.valid) @(posedge clk);
			got.frame_now   = out_bus.frame_now;
			got.rect_left   = out_bus.rect_left;
			got.rect_top    = out_bus.rect_top;
			got.rect_right  = out_bus.rect_right;
			got.rect_bottom = out_bus.rect_bottom;
			got.done_flag   = out_bus.done_flag;
			tracker.check_frame(got);
		end
	end

	initial begin
		#5_000_000;
		$display("sprite_frame_animator: mismatch");
		$finish;
	end

	initial begin
		tracker             = new();
		calm                = 1'b0;
		arst_n              = 1'b0;
		cfg_wen             = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		in_bus.valid        = 1'b0;
		in_bus.func         = sfa_pkg::FUNC_TICK;
		in_bus.elapsed_time = '0;
		in_bus.frame_value  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: sequence not animated, negative loads ignored
		send_beat(sfa_pkg::FUNC_TICK, '1, 16'hFFFF);
		send_beat(sfa_pkg::FUNC_SET, '1, 16'h7FFF);
		send_beat(sfa_pkg::FUNC_SET, '0, 16'h8000);
		send_beat(sfa_pkg::FUNC_SET, '0, 16'hFFFF);
		send_beat(sfa_pkg::FUNC_TICK, '0, 16'h0000);

		// looping range 2..5: equal time holds, saturation, wrap from above and below
		load_setup(16'd2, 16'd5, 1'b1, 32'h0001_0000, 8'd3, 12'd16, 12'd8);
		send_beat(sfa_pkg::FUNC_SET, '0, 16'd2);
		send_beat(sfa_pkg::FUNC_TICK, 32'h0001_0000, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, 32'd1, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, '1, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, '1, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, '1, 16'h0);
		send_beat(sfa_pkg::FUNC_SET, '0, 16'd100);
		send_beat(sfa_pkg::FUNC_TICK, 32'h0002_0000, 16'h0);
		send_beat(sfa_pkg::FUNC_SET, '0, 16'd0);
		send_beat(sfa_pkg::FUNC_TICK, 32'h0002_0000, 16'h0);

		// top of the index range, stop at the end, zero columns and zero width
		load_setup(16'hFFFE, 16'hFFFF, 1'b0, 32'd0, 8'd0, 12'd0, 12'hFFF);
		send_beat(sfa_pkg::FUNC_SET, '0, 16'h7FFF);
		send_beat(sfa_pkg::FUNC_TICK, 32'd1, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, 32'd1, 16'h0);
		send_beat(sfa_pkg::FUNC_SET, '0, 16'd5);

		load_setup(16'hFFFE, 16'hFFFF, 1'b1, 32'd0, 8'd255, 12'hFFF, 12'hFFF);
		send_beat(sfa_pkg::FUNC_TICK, 32'd1, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, 32'd1, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, 32'd1, 16'h0);
		send_beat(sfa_pkg::FUNC_TICK, 32'd0, 16'h0);

		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph % 4 == 2);
			random_phase(95);
		end

		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (tracker.frames_due.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("sprite_frame_animator: match");
		else
			$display("sprite_frame_animator: mismatch");
		$finish;
	end

endmodule
